/* rtl/stb_pkg.sv */
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants of the software timer bank: request codes,
// status codes, per-slot cell operations and the slot status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package stb_pkg;

  // Widest bank the index helpers below cover.
  localparam int MaxSlots = 64;
  // Largest number of fired slots reported by one elapse item.
  localparam int MaxResults = 16;
  localparam int ResCntW = $clog2(MaxResults);

  typedef enum logic [2:0] {
    REQ_ALLOC      = 3'd0,
    REQ_FREE       = 3'd1,
    REQ_START_ONE  = 3'd2,
    REQ_START_PER  = 3'd3,
    REQ_STOP       = 3'd4,
    REQ_RELOAD     = 3'd5,
    REQ_ELAPSE     = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_ALLOC     = 3'd1,
    OP_FREE      = 3'd2,
    OP_START_ONE = 3'd3,
    OP_START_PER = 3'd4,
    OP_STOP      = 3'd5,
    OP_RELOAD    = 3'd6
  } cell_op_e;

  // What one slot cell reports to the controller.
  typedef struct packed {
    logic used;
    logic active;
    logic fire;   // pending expiry reported while the walk token is here
    logic drop;   // a one-shot timer left the active set during the walk
  } cell_stat_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [5:0] lowest_set(input logic [MaxSlots-1:0] v);
    logic [5:0] idx;
    idx = '0;
    for (int i = MaxSlots - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = 6'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

/* rtl/stb_cell.sv */
// ----------------------------------------------------------------------------
// stb_cell
// One timer slot: its flags, period and counter. A command updates the cell
// when it is selected; an elapse walk updates it when the token arrives, and
// the token moves on to the next cell in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stb_cell import stb_pkg::*; #(
  parameter int PERIOD_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cell_op_e               op_i,
  input  wire logic                   sel_i,
  input  wire logic [PERIOD_BITS-1:0] period_i,
  input  wire logic                   tok_i,
  input  wire logic [31:0]            diff_i,
  output logic                        tok_o,
  output cell_stat_t                  stat_o
);

  logic used_q, used_d;
  logic active_q, active_d;
  logic periodic_q, periodic_d;
  logic pending_q, pending_d;
  logic tok_q;
  logic [PERIOD_BITS-1:0] period_q, period_d;
  logic [PERIOD_BITS-1:0] count_q, count_d;

  logic fire, oneshot_done, act_mid, ge;
  logic [PERIOD_BITS-1:0] cnt_mid, cnt_sub;

  assign fire         = tok_i & used_q & pending_q;
  assign oneshot_done = fire & ~periodic_q;
  assign act_mid      = active_q & ~oneshot_done;
  assign cnt_mid      = oneshot_done ? period_q : count_q;
  assign ge           = 32'(cnt_mid) >= diff_i;
  assign cnt_sub      = cnt_mid - PERIOD_BITS'(diff_i);

  always_comb begin
    used_d     = used_q;
    active_d   = active_q;
    periodic_d = periodic_q;
    pending_d  = pending_q;
    period_d   = period_q;
    count_d    = count_q;

    if (tok_i && used_q) begin
      if (fire) begin
        pending_d = 1'b0;
      end
      active_d = act_mid;
      count_d  = cnt_mid;
      if (act_mid) begin
        if (ge) begin
          if (cnt_sub == '0) begin
            count_d   = period_q;
            pending_d = 1'b1;
          end else begin
            count_d = cnt_sub;
          end
        end else begin
          // Overshoot: the counter stays at zero until reloaded.
          count_d   = '0;
          pending_d = 1'b1;
        end
      end
    end

    if (sel_i) begin
      case (op_i)
        OP_ALLOC: begin
          used_d     = 1'b1;
          period_d   = period_i;
          count_d    = period_i;
          active_d   = 1'b0;
          periodic_d = 1'b0;
          pending_d  = 1'b0;
        end
        OP_FREE: begin
          used_d     = 1'b0;
          active_d   = 1'b0;
          periodic_d = 1'b0;
          pending_d  = 1'b0;
        end
        OP_START_ONE: begin
          count_d    = period_q;
          periodic_d = 1'b0;
          active_d   = 1'b1;
        end
        OP_START_PER: begin
          count_d    = period_q;
          periodic_d = 1'b1;
          active_d   = 1'b1;
        end
        OP_STOP: begin
          count_d  = period_q;
          active_d = 1'b0;
        end
        OP_RELOAD: begin
          count_d = period_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= 1'b0;
      active_q   <= 1'b0;
      periodic_q <= 1'b0;
      pending_q  <= 1'b0;
      tok_q      <= 1'b0;
    end else begin
      used_q     <= used_d;
      active_q   <= active_d;
      periodic_q <= periodic_d;
      pending_q  <= pending_d;
      tok_q      <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    period_q <= period_d;
    count_q  <= count_d;
  end

  assign tok_o         = tok_q;
  assign stat_o.used   = used_q;
  assign stat_o.active = active_q;
  assign stat_o.fire   = fire;
  assign stat_o.drop   = oneshot_done & active_q;

endmodule

`default_nettype wire

/* rtl/software_timer_bank.sv */
// ----------------------------------------------------------------------------
// software_timer_bank
// Bank of countdown timers held in a row of slot cells, with a controller
// that decodes commands, walks the cells on elapse and reports fired slots.
// ----------------------------------------------------------------------------
// Usage: the request channel (in_valid_i/in_ready_o) carries one command
// item; the result channel (out_valid_o/out_ready_i) returns its results.
// Every command but elapse returns one result with last_o set. An elapse
// with a nonzero tick count returns one result per fired slot in slot order
// (at most 16), last_o on the final one, or a single plain result if none
// fired. active_count_o is the active timer count after the whole item.
// A command is latched on acceptance and its result is registered from the
// execute step; a new item is taken only once the block is back in idle. An
// elapse passes a token down the slot chain, one cell per cycle, and then
// reports its results one by one from the report step.
// The output register frees the request side: an item is accepted while the
// previous result still waits; a stalled receiver holds the block in its
// command or report step until the result register drains.
// Reset clears all slots to unallocated and the active count to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module software_timer_bank import stb_pkg::*; #(
  parameter int NUM_SLOTS   = 16,
  parameter int PERIOD_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [3:0]  slot_index_i,
  input  wire logic [15:0] period_value_i,
  input  wire logic [31:0] elapsed_ticks_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [3:0]       result_slot_o,
  output logic             fired_valid_o,
  output logic [4:0]       active_count_o,
  output logic             last_o
);

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CntW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WALK = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Latched request.
  logic [2:0]  req_q;
  logic [3:0]  slot_q;
  logic [15:0] period_q;
  logic [31:0] diff_q;

  logic [CntW-1:0]      active_total_q, active_total_d;
  logic [NUM_SLOTS-1:0] fire_mask_q, fire_mask_d;
  logic [ResCntW-1:0]   nres_q, nres_d;

  // Result register.
  logic       out_valid_q, out_load;
  logic [1:0] status_q, status_d;
  logic [3:0] rslot_q, rslot_d;
  logic       fired_q, fired_d;
  logic [4:0] act_q, act_d;
  logic       last_q, last_d;

  // Cell row.
  logic [NUM_SLOTS:0]   tok;
  logic                 tok_start;
  cell_stat_t           stat [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] used_vec, active_vec, fire_vec, drop_vec, sel_vec;
  cell_op_e             cell_op;
  logic [PERIOD_BITS-1:0] cell_period;

  logic in_fire, out_free;
  logic [NUM_SLOTS-1:0] free_vec, free_low, emit_low, emit_rest;
  logic [IdxW-1:0] sel_idx, alloc_idx, emit_idx;
  logic slot_ok, sel_active, emit_last;
  logic [CntW-1:0] total_next;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  assign tok[0] = tok_start;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    stb_cell #(
      .PERIOD_BITS (PERIOD_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .op_i     (cell_op),
      .sel_i    (sel_vec[i]),
      .period_i (cell_period),
      .tok_i    (tok[i]),
      .diff_i   (diff_q),
      .tok_o    (tok[i+1]),
      .stat_o   (stat[i])
    );
    assign used_vec[i]   = stat[i].used;
    assign active_vec[i] = stat[i].active;
    assign fire_vec[i]   = stat[i].fire;
    assign drop_vec[i]   = stat[i].drop;
  end

  assign cell_period = PERIOD_BITS'(period_q);

  assign free_vec  = ~used_vec;
  assign free_low  = free_vec & (~free_vec + NUM_SLOTS'(1));
  assign alloc_idx = IdxW'(lowest_set(MaxSlots'(free_vec)));
  assign sel_idx   = IdxW'(slot_q);
  assign slot_ok   = (32'(slot_q) < NUM_SLOTS) && used_vec[sel_idx];
  assign sel_active = active_vec[sel_idx];

  assign emit_low  = fire_mask_q & (~fire_mask_q + NUM_SLOTS'(1));
  assign emit_rest = fire_mask_q & ~emit_low;
  assign emit_idx  = IdxW'(lowest_set(MaxSlots'(fire_mask_q)));
  assign emit_last = (emit_rest == '0) || (nres_q == ResCntW'(MaxResults - 1));

  function automatic logic [4:0] sat_count(input logic [CntW-1:0] v);
    return (32'(v) > 31) ? 5'd31 : 5'(v);
  endfunction

  always_comb begin
    state_d        = state_q;
    active_total_d = active_total_q;
    fire_mask_d    = fire_mask_q;
    nres_d         = nres_q;
    out_load       = 1'b0;
    status_d       = ST_OK;
    rslot_d        = '0;
    fired_d        = 1'b0;
    act_d          = sat_count(active_total_q);
    last_d         = 1'b1;
    cell_op        = OP_NONE;
    sel_vec        = '0;
    tok_start      = 1'b0;
    total_next     = active_total_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        nres_d = '0;
        if (req_q == REQ_ELAPSE && diff_q != '0) begin
          tok_start = 1'b1;
          state_d   = S_WALK;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          case (req_q)
            REQ_ALLOC: begin
              if (free_vec != '0) begin
                cell_op = OP_ALLOC;
                sel_vec = free_low;
                rslot_d = 4'(alloc_idx);
              end else begin
                status_d = ST_FULL;
              end
            end
            REQ_FREE, REQ_START_ONE, REQ_START_PER, REQ_STOP, REQ_RELOAD: begin
              if (slot_ok) begin
                sel_vec = NUM_SLOTS'(1) << sel_idx;
                case (req_q)
                  REQ_FREE: begin
                    cell_op = OP_FREE;
                    if (sel_active) total_next = active_total_q - CntW'(1);
                  end
                  REQ_START_ONE: begin
                    cell_op = OP_START_ONE;
                    if (!sel_active) total_next = active_total_q + CntW'(1);
                  end
                  REQ_START_PER: begin
                    cell_op = OP_START_PER;
                    if (!sel_active) total_next = active_total_q + CntW'(1);
                  end
                  REQ_STOP: begin
                    cell_op = OP_STOP;
                    if (sel_active) total_next = active_total_q - CntW'(1);
                  end
                  default: begin
                    cell_op = OP_RELOAD;
                  end
                endcase
              end else begin
                status_d = ST_BAD;
              end
            end
            default: begin
            end
          endcase
          active_total_d = total_next;
          act_d          = sat_count(total_next);
        end
      end

      S_WALK: begin
        if (tok[NUM_SLOTS]) begin
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (fire_mask_q == '0) begin
            state_d = S_IDLE;
          end else begin
            rslot_d = 4'(emit_idx);
            fired_d = 1'b1;
            last_d  = emit_last;
            nres_d  = nres_q + ResCntW'(1);
            if (emit_last) begin
              // Fired slots beyond the report limit are dropped here.
              fire_mask_d = '0;
              state_d     = S_IDLE;
            end else begin
              fire_mask_d = emit_rest;
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Walk bookkeeping: the token sits in at most one cell in any cycle.
    if (state_q == S_EXEC || state_q == S_WALK) begin
      fire_mask_d = fire_mask_q | fire_vec;
      if (drop_vec != '0) begin
        active_total_d = active_total_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      active_total_q <= '0;
      fire_mask_q    <= '0;
      nres_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      active_total_q <= active_total_d;
      fire_mask_q    <= fire_mask_d;
      nres_q         <= nres_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q    <= req_type_i;
      slot_q   <= slot_index_i;
      period_q <= period_value_i;
      diff_q   <= elapsed_ticks_i;
    end
    if (out_load) begin
      status_q <= status_d;
      rslot_q  <= rslot_d;
      fired_q  <= fired_d;
      act_q    <= act_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign result_slot_o  = rslot_q;
  assign fired_valid_o  = fired_q;
  assign active_count_o = act_q;
  assign last_o         = last_q;

`ifndef SYNTHESIS
  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fired_valid_o |-> status_o == ST_OK)
    else $error("fired result carries a non-ok status");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok))
    else $error("more than one walk token in the slot chain");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> fire_mask_q == '0)
    else $error("fired slots left unreported at idle");

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(active_total_q) <= NUM_SLOTS)
    else $error("active timer count exceeds the number of slots");
`endif

endmodule

`default_nettype wire
